[design/ipe_pkg.sv]
package ipe_pkg;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_OP     = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_BADOP   = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    typedef struct packed {
        logic take;
        logic step;
        logic done;
    } t_ctrl_cmd;

    typedef struct packed {
        logic long_op;
        logic is_div;
        logic out_free;
    } t_dp_stat;

endpackage

[design/infix_precedence_evaluator.sv]
// Streaming evaluator for infix expressions over + - * / with two precedence
// levels, on signed fixed-point numbers (VALUE_WIDTH bits, FRACTION_BITS of
// fraction).
// Input request: s_axis_tuser carries command and operator code, s_axis_tdata
// the operand. Every request yields exactly one response: m_axis_tdata holds
// the value (nonzero only on finish), m_axis_tuser the status.
// Start, finish, add, subtract, an unknown command, a zero divisor, an invalid
// operator and any request after an error: response in the cycle after accept,
// one request per cycle when the output is drained.
// Multiply and divide by a nonzero divisor: the product comes from the
// bit-serial shift-add multiplier, the quotient from the restoring divider that
// retires one quotient bit a cycle; the result is then written to the output
// register, and no new request is taken until that write is done.
// Reset clears the running sum, the term and its sign, the error latch and the
// output valid flag; an operator before any start works on the value zero.
// While the receiver holds m_axis_tready low the response is held in the output
// register and new requests stall once that register is full.
module infix_precedence_evaluator #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // operand
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    // command [1:0], operator_code [4:2]
    input  logic [4:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // value
    output logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,
    // status [1:0]
    output logic [1:0]                             m_axis_tuser
);

    localparam int DATA_BYTES = (VALUE_WIDTH + 7) / 8;

    ipe_pkg::t_ctrl_cmd     cmd;
    ipe_pkg::t_dp_stat      stat;
    logic [VALUE_WIDTH-1:0] value;

    ipe_ctrl #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ipe_dp #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_command       (s_axis_tuser[1:0]),
        .i_operator_code (s_axis_tuser[4:2]),
        .i_operand       (s_axis_tdata[VALUE_WIDTH-1:0]),
        .o_value         (value),
        .o_status        (m_axis_tuser),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready)
    );

    assign m_axis_tdata = (DATA_BYTES*8)'(value);

endmodule

[design/ipe_ctrl.sv]
module ipe_ctrl #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  ipe_pkg::t_dp_stat  i_stat,
    output ipe_pkg::t_ctrl_cmd o_cmd
);

    localparam int DIV_STEPS = VALUE_WIDTH + FRACTION_BITS;
    localparam int CW        = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          take;

    assign o_req_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign take        = i_req_valid && o_req_ready;

    assign o_cmd.take = take;
    assign o_cmd.step = (r_state == S_RUN);
    assign o_cmd.done = (r_state == S_FIN) && i_stat.out_free;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (take && i_stat.long_op) begin
                    n_state = S_RUN;
                    n_cnt   = i_stat.is_div ? CW'(DIV_STEPS) : CW'(VALUE_WIDTH);
                end
            end
            S_RUN: begin
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[design/ipe_dp.sv]
module ipe_dp #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ipe_pkg::t_ctrl_cmd     i_cmd,
    output ipe_pkg::t_dp_stat      o_stat,
    input  logic [1:0]             i_command,
    input  logic [2:0]             i_operator_code,
    input  logic [VALUE_WIDTH-1:0] i_operand,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [1:0]             o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready
);

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int L  = W + F;
    localparam int XW = 2 * W + F;

    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat_addsub(input logic [W-1:0] a,
                                                input logic [W-1:0] b,
                                                input logic sub);
        logic [W:0] s;
        logic [W-1:0] res;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        if (s[W] != s[W-1]) begin
            res = s[W] ? VMIN : VMAX;
        end else begin
            res = s[W-1:0];
        end
        return res;
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    logic [W-1:0] r_sum, n_sum;
    logic [W-1:0] r_term, n_term;
    logic         r_neg, n_neg;
    logic [1:0]   r_err, n_err;
    logic [W-1:0] r_ua, r_ub;
    logic         r_res_neg;
    logic         r_is_div;
    logic [W-1:0] r_up, r_ml;
    logic [W-1:0] r_rem;
    logic [L-1:0] r_num;
    logic [W-1:0] r_value, n_value;
    logic [1:0]   r_status, n_status;
    logic         r_out_valid;
    logic         write_out;

    logic         err_on, is_op, op_mul, op_div, x_zero;
    logic [W-1:0] folded;
    logic [W-1:0] mag_term, mag_x;
    logic [W:0]   mul_t;
    logic [W:0]   div_rs;
    logic         div_ge;
    logic [XW-1:0] res_mag, res_lim;
    logic [W-1:0] res_val;

    assign err_on  = (r_err != ipe_pkg::ST_OK);
    assign is_op   = (i_command == ipe_pkg::CMD_OP);
    assign x_zero  = (i_operand == '0);
    assign op_mul  = is_op && !err_on && (i_operator_code == ipe_pkg::OP_MUL);
    assign op_div  = is_op && !err_on && (i_operator_code == ipe_pkg::OP_DIV) && !x_zero;
    assign folded  = sat_addsub(r_sum, r_term, r_neg);
    assign mag_term = mag(r_term);
    assign mag_x    = mag(i_operand);

    assign o_stat.long_op  = op_mul || op_div;
    assign o_stat.is_div   = op_div;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign mul_t  = {1'b0, r_up} + (r_ml[0] ? {1'b0, r_ua} : {(W+1){1'b0}});
    assign div_rs = {r_rem, r_num[L-1]};
    assign div_ge = (div_rs >= {1'b0, r_ub});

    always_comb begin
        res_mag = r_is_div ? XW'(r_num) : XW'({r_up, r_ml} >> F);
        res_lim = XW'(VMAX) + XW'(r_res_neg);
        if (res_mag > res_lim) begin
            res_val = r_res_neg ? VMIN : VMAX;
        end else if (r_res_neg) begin
            res_val = ~res_mag[W-1:0] + W'(1);
        end else begin
            res_val = res_mag[W-1:0];
        end
    end

    always_comb begin
        n_sum     = r_sum;
        n_term    = r_term;
        n_neg     = r_neg;
        n_err     = r_err;
        n_value   = '0;
        n_status  = ipe_pkg::ST_OK;
        write_out = 1'b0;
        if (i_cmd.take && !(op_mul || op_div)) begin
            write_out = 1'b1;
            if (i_command == ipe_pkg::CMD_START) begin
                n_sum  = '0;
                n_term = i_operand;
                n_neg  = 1'b0;
                n_err  = ipe_pkg::ST_OK;
            end else if ((is_op || i_command == ipe_pkg::CMD_FINISH) && err_on) begin
                n_status = r_err;
            end else if (is_op) begin
                case (i_operator_code)
                    ipe_pkg::OP_ADD, ipe_pkg::OP_SUB: begin
                        n_sum  = folded;
                        n_term = i_operand;
                        n_neg  = (i_operator_code == ipe_pkg::OP_SUB);
                    end
                    ipe_pkg::OP_DIV: begin
                        n_err    = ipe_pkg::ST_DIVZERO;
                        n_status = ipe_pkg::ST_DIVZERO;
                    end
                    default: begin
                        n_err    = ipe_pkg::ST_BADOP;
                        n_status = ipe_pkg::ST_BADOP;
                    end
                endcase
            end else if (i_command == ipe_pkg::CMD_FINISH) begin
                n_value  = folded;
                n_status = ipe_pkg::ST_DONE;
            end
        end else if (i_cmd.done) begin
            write_out = 1'b1;
            n_term    = res_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_term      <= '0;
            r_neg       <= 1'b0;
            r_err       <= ipe_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_sum  <= n_sum;
            r_term <= n_term;
            r_neg  <= n_neg;
            r_err  <= n_err;
            if (write_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (write_out) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
        if (i_cmd.take) begin
            r_ua      <= mag_term;
            r_ub      <= mag_x;
            r_res_neg <= r_term[W-1] ^ i_operand[W-1];
            r_is_div  <= (i_operator_code == ipe_pkg::OP_DIV);
            r_up      <= '0;
            r_ml      <= mag_x;
            r_rem     <= '0;
            r_num     <= L'(mag_term) << F;
        end else if (i_cmd.step) begin
            if (r_is_div) begin
                r_rem <= div_ge ? W'(div_rs - {1'b0, r_ub}) : div_rs[W-1:0];
                r_num <= {r_num[L-2:0], div_ge};
            end else begin
                r_up <= mul_t[W:1];
                r_ml <= {mul_t[0], r_ml[W-1:1]};
            end
        end
    end

    assign o_value     = r_value;
    assign o_status    = r_status;
    assign o_out_valid = r_out_valid;

endmodule

[sim/infix_precedence_evaluator_checker.sv]
`timescale 1ns / 100ps

module infix_precedence_evaluator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // operand
    input  logic [31:0] i_s_tdata,
    // command [1:0], operator_code [4:2]
    input  logic [4:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // value
    input  logic [31:0] i_m_tdata,
    // status [1:0]
    input  logic [1:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_done_count,
    output int          o_error_count
);

    localparam int     FRAC_BITS = 16;
    localparam longint VAL_MAX   = 64'sd2147483647;
    localparam longint VAL_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_response;

    t_response          expected_q[$];
    logic signed [31:0] sum_acc   = '0;
    logic signed [31:0] term_acc  = '0;
    logic               term_neg  = 1'b0;
    logic [1:0]         err_latch = ipe_pkg::ST_OK;
    int                 fail_cnt  = 0;
    int                 done_cnt  = 0;
    int                 err_cnt   = 0;

    function automatic logic [31:0] clamp_val(input longint s);
        longint c;
        c = s;
        if (c > VAL_MAX) c = VAL_MAX;
        if (c < VAL_MIN) c = VAL_MIN;
        return c[31:0];
    endfunction

    function automatic longint unsigned abs_mag(input logic signed [31:0] a);
        longint s;
        s = a;
        return (s < 0) ? -s : s;
    endfunction

    function automatic logic [31:0] signed_from_mag(input longint unsigned mag,
                                                    input logic neg);
        longint unsigned lim;
        logic [63:0]     r;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (mag > lim) mag = lim;
        r = neg ? -mag : mag;
        return r[31:0];
    endfunction

    function automatic logic [31:0] fixed_mul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        return signed_from_mag((abs_mag(a) * abs_mag(b)) >> FRAC_BITS, a[31] ^ b[31]);
    endfunction

    function automatic logic [31:0] fixed_div(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        return signed_from_mag((abs_mag(a) << FRAC_BITS) / abs_mag(b), a[31] ^ b[31]);
    endfunction

    function automatic logic [31:0] folded_value();
        longint s;
        s = term_neg ? longint'(sum_acc) - longint'(term_acc)
                     : longint'(sum_acc) + longint'(term_acc);
        return clamp_val(s);
    endfunction

    function automatic t_response eval_request(input logic [1:0] cmd,
                                               input logic [2:0] op,
                                               input logic signed [31:0] x);
        t_response r;
        r.value  = '0;
        r.status = ipe_pkg::ST_OK;
        if (cmd == ipe_pkg::CMD_START) begin
            sum_acc   = '0;
            term_acc  = x;
            term_neg  = 1'b0;
            err_latch = ipe_pkg::ST_OK;
        end else if ((cmd == ipe_pkg::CMD_OP || cmd == ipe_pkg::CMD_FINISH)
                     && err_latch != ipe_pkg::ST_OK) begin
            r.status = err_latch;
        end else if (cmd == ipe_pkg::CMD_OP) begin
            case (op)
                ipe_pkg::OP_ADD, ipe_pkg::OP_SUB: begin
                    sum_acc  = folded_value();
                    term_acc = x;
                    term_neg = (op == ipe_pkg::OP_SUB);
                end
                ipe_pkg::OP_MUL: begin
                    term_acc = fixed_mul(term_acc, x);
                end
                ipe_pkg::OP_DIV: begin
                    if (x == 0) begin
                        err_latch = ipe_pkg::ST_DIVZERO;
                        r.status  = ipe_pkg::ST_DIVZERO;
                    end else begin
                        term_acc = fixed_div(term_acc, x);
                    end
                end
                default: begin
                    err_latch = ipe_pkg::ST_BADOP;
                    r.status  = ipe_pkg::ST_BADOP;
                end
            endcase
        end else if (cmd == ipe_pkg::CMD_FINISH) begin
            r.value  = folded_value();
            r.status = ipe_pkg::ST_DONE;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_response want;
        if (!i_rst_n) begin
            sum_acc   = '0;
            term_acc  = '0;
            term_neg  = 1'b0;
            err_latch = ipe_pkg::ST_OK;
            expected_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                want = eval_request(i_s_tuser[1:0], i_s_tuser[4:2], i_s_tdata);
                expected_q.insert(expected_q.size(), want);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected response: value %h status %0d", i_m_tdata, i_m_tuser);
                    fail_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_m_tdata !== want.value) begin
                        $error("value: expected %h, actual %h", want.value, i_m_tdata);
                        fail_cnt++;
                    end
                    if (i_m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_m_tuser);
                        fail_cnt++;
                    end
                    if (want.status == ipe_pkg::ST_DONE) begin
                        done_cnt++;
                    end else if (want.status != ipe_pkg::ST_OK) begin
                        err_cnt++;
                    end
                end
            end
        end
        o_pending     <= expected_q.size();
        o_fail_count  <= fail_cnt;
        o_done_count  <= done_cnt;
        o_error_count <= err_cnt;
    end

endmodule

[sim/infix_precedence_evaluator_tb.sv]
`timescale 1ns / 100ps

module infix_precedence_evaluator_tb;

    localparam logic [1:0]  CMD_NONE     = 2'd3;
    localparam logic [2:0]  OP_BAD_FIRST = 3'd4;
    localparam logic [2:0]  OP_BAD_LAST  = 3'd7;
    localparam int          ITEMS        = 1700;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [31:0] Q_ONE        = 32'h0001_0000;
    localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN        = 32'h8000_0000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [4:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int done_count;
    int error_count;
    int sent_cnt  = 0;
    int cycle_cnt = 0;
    bit hold_req  = 1'b0;

    infix_precedence_evaluator u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    infix_precedence_evaluator_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_done_count  (done_count),
        .o_error_count (error_count)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        #8_000_000;
        $display("infix_precedence_evaluator_tb: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return ipe_pkg::OP_ADD;
        if (r < 50) return ipe_pkg::OP_SUB;
        if (r < 72) return ipe_pkg::OP_MUL;
        if (r < 94) return ipe_pkg::OP_DIV;
        return 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ONE;
                    3: return -Q_ONE;
                    default: return 32'h0000_0001;
                endcase
            end
            2: return '0;
            default: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
        endcase
    endfunction

    task automatic send_req(input logic [1:0] cmd, input logic [2:0] op,
                            input logic [31:0] data, input bit calm);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= {op, cmd};
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        sent_cnt++;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial begin : receiver
        int stall;
        int calm_left;
        bit calm;
        stall     = 0;
        calm_left = 0;
        calm      = 1'b0;
        forever begin
            @(posedge clk);
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = 256;
            end
            calm_left--;
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 2) == 0) stall = pick_gap();
            end
        end
    end

    initial begin : stimulus
        bit          calm;
        int          n_ops;
        int          next_hold;
        logic [2:0]  op;
        logic [31:0] arg;
        next_hold = 500;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_req(ipe_pkg::CMD_OP,     ipe_pkg::OP_ADD, 32'h0002_0000, 1'b0);
        send_req(ipe_pkg::CMD_FINISH, ipe_pkg::OP_ADD, '0,            1'b0);
        send_req(ipe_pkg::CMD_START,  ipe_pkg::OP_ADD, Q_ONE,         1'b0);
        send_req(ipe_pkg::CMD_OP,     ipe_pkg::OP_MUL, 32'h0002_8000, 1'b0);
        send_req(ipe_pkg::CMD_OP,     ipe_pkg::OP_ADD, 32'h0003_0000, 1'b0);
        send_req(ipe_pkg::CMD_OP,     ipe_pkg::OP_DIV, 32'hFFFE_0000, 1'b0);
        send_req(ipe_pkg::CMD_FINISH, ipe_pkg::OP_ADD, '0,            1'b0);
        send_req(ipe_pkg::CMD_OP,     ipe_pkg::OP_SUB, Q_MAX,         1'b0);
        send_req(ipe_pkg::CMD_FINISH, ipe_pkg::OP_ADD, '0,            1'b0);
        send_req(ipe_pkg::CMD_START,  OP_BAD_LAST,     Q_MIN,         1'b0);
        send_req(ipe_pkg::CMD_OP,     ipe_pkg::OP_MUL, Q_MIN,         1'b0);
        send_req(ipe_pkg::CMD_OP,     ipe_pkg::OP_SUB, Q_MIN,         1'b0);
        send_req(ipe_pkg::CMD_FINISH, ipe_pkg::OP_ADD, '0,            1'b0);
        send_req(ipe_pkg::CMD_START,  ipe_pkg::OP_ADD, Q_MAX,         1'b0);
        send_req(ipe_pkg::CMD_OP,     ipe_pkg::OP_DIV, 32'h0000_0001, 1'b0);
        send_req(ipe_pkg::CMD_OP,     ipe_pkg::OP_DIV, '0,            1'b0);
        send_req(ipe_pkg::CMD_OP,     ipe_pkg::OP_ADD, Q_ONE,         1'b0);
        send_req(ipe_pkg::CMD_FINISH, ipe_pkg::OP_ADD, '0,            1'b0);
        send_req(CMD_NONE,            OP_BAD_LAST,     32'hFFFF_FFFF, 1'b0);
        send_req(ipe_pkg::CMD_START,  ipe_pkg::OP_ADD, '0,            1'b0);
        send_req(ipe_pkg::CMD_OP,     OP_BAD_FIRST,    Q_ONE,         1'b0);
        send_req(ipe_pkg::CMD_FINISH, ipe_pkg::OP_ADD, '0,            1'b0);
        send_req(ipe_pkg::CMD_START,  ipe_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0);
        send_req(ipe_pkg::CMD_FINISH, ipe_pkg::OP_ADD, '0,            1'b0);
        send_req(ipe_pkg::CMD_FINISH, ipe_pkg::OP_ADD, '0,            1'b0);

        while (sent_cnt < ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if (sent_cnt >= next_hold) begin
                hold_req = 1'b1;
                next_hold += 700;
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_req(2'($urandom_range(ipe_pkg::CMD_START, CMD_NONE)),
                             3'($urandom_range(ipe_pkg::OP_ADD, OP_BAD_LAST)),
                             rand_operand(), calm);
                end
            end else begin
                send_req(ipe_pkg::CMD_START, 3'($urandom_range(ipe_pkg::OP_ADD, OP_BAD_LAST)),
                         rand_operand(), calm);
                n_ops = $urandom_range(1, 6);
                repeat (n_ops) begin
                    op  = pick_op();
                    arg = rand_operand();
                    if (op == ipe_pkg::OP_DIV && arg == '0 && $urandom_range(0, 3) != 0) begin
                        arg = Q_ONE;
                    end
                    send_req(ipe_pkg::CMD_OP, op, arg, calm);
                end
                send_req(ipe_pkg::CMD_FINISH, 3'($urandom_range(ipe_pkg::OP_ADD, OP_BAD_LAST)),
                         $urandom(), calm);
                if ($urandom_range(0, 5) == 0) begin
                    send_req(ipe_pkg::CMD_FINISH, ipe_pkg::OP_ADD, $urandom(), calm);
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Ran %0d requests in %0d cycles: precedence chains, saturation, zero divisors,",
                 sent_cnt, cycle_cnt);
        $display("bad operators and stray commands; %0d finished results, %0d error responses.",
                 done_count, error_count);
        if (fail_count == 0 && pending == 0) begin
            $display("infix_precedence_evaluator_tb: PASS");
        end else begin
            $display("infix_precedence_evaluator_tb: FAIL");
        end
        $finish;
    end

endmodule
